/* rtl/bba_pkg.sv */
`timescale 1ns / 1ps

package bba_pkg;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [2:0] ST_NO_SPACE  = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;

    localparam int MODE_W = 2;
    localparam int SIZE_W = 24;
    localparam int ADDR_W = 48;
    localparam int CNT_W  = 11;
    localparam int FRAG_W = 7;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_START,
        OP_A_EVAL,
        OP_A_MARK,
        OP_F_EVAL,
        OP_F_LEN,
        OP_F_CLR,
        OP_S_EVAL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FIN
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       size_zero;
        logic       addr_zero;
        logic       last;
        logic       a_hit;
        logic       f_match;
        logic       len_zero;
        logic       mark_done;
        logic       clr_done;
        logic       div_done;
    } stat_t;

endpackage

/* rtl/bba_dpath.sv */
`timescale 1ns / 1ps

module bba_dpath import bba_pkg::*; #(
    parameter int NUM_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_wdata,
    input  logic [MODE_W-1:0] in_mode,
    input  logic [SIZE_W-1:0] in_size,
    input  logic [ADDR_W-1:0] in_address,
    output logic [2:0]        out_status,
    output logic [ADDR_W-1:0] out_block_address,
    output logic [CNT_W-1:0]  out_used_count,
    output logic [CNT_W-1:0]  out_avail_count,
    output logic [CNT_W-1:0]  out_longest_free_run,
    output logic [FRAG_W-1:0] out_frag_pct
);

    localparam int AW  = $clog2(NUM_BLOCKS);
    localparam int IW  = AW + 1;
    localparam int RBW = SIZE_W + 2;
    localparam int NW  = IW + FRAG_W;
    localparam int XW  = ADDR_W + 1;

    logic [ADDR_W-1:0] base_reg, base_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic [RBW-1:0]    rb_reg, rb_next;
    logic [XW-1:0]     acur_reg, acur_next;
    logic [XW-1:0]     run_addr_reg, run_addr_next;
    logic [IW-1:0]     start_reg, start_next;
    logic [IW-1:0]     used_reg, used_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic [IW-1:0]     longest_reg, longest_next;
    logic [IW-1:0]     free_reg, free_next;
    logic [NW-1:0]     rem_reg, rem_next;
    logic [FRAG_W-1:0] quo_reg, quo_next;
    logic [2:0]        k_reg, k_next;

    logic [2:0]        o_status_reg, o_status_next;
    logic [ADDR_W-1:0] o_addr_reg, o_addr_next;
    logic [CNT_W-1:0]  o_alloc_reg, o_alloc_next;
    logic [CNT_W-1:0]  o_free_reg, o_free_next;
    logic [CNT_W-1:0]  o_long_reg, o_long_next;
    logic [FRAG_W-1:0] o_frag_reg, o_frag_next;

    // Block state memories; read data is registered from the current index.
    logic          used_mem [NUM_BLOCKS];
    logic [IW-1:0] run_mem  [NUM_BLOCKS];
    logic          used_q;
    logic [IW-1:0] run_q;
    logic          used_we, used_wd, run_we;
    logic [IW-1:0] run_wd;
    logic [NW-1:0] div_term;

    always_ff @(posedge aclk) begin
        used_q <= used_mem[idx_reg[AW-1:0]];
        run_q  <= run_mem[idx_reg[AW-1:0]];
        if (used_we) begin
            used_mem[idx_reg[AW-1:0]] <= used_wd;
        end
        if (run_we) begin
            run_mem[idx_reg[AW-1:0]] <= run_wd;
        end
    end

    always_comb begin
        stat.mode      = mode_reg;
        stat.size_zero = (size_reg == '0);
        stat.addr_zero = (addr_reg == '0);
        stat.last      = (idx_reg == IW'(NUM_BLOCKS - 1));
        stat.a_hit     = !used_q && ((rb_reg + RBW'(BLOCK_BYTES)) >= RBW'(size_reg));
        stat.f_match   = (acur_reg == {1'b0, addr_reg});
        stat.len_zero  = (run_q == '0);
        stat.mark_done = (idx_reg == start_reg + cnt_reg - IW'(1));
        stat.clr_done  = (cnt_reg == IW'(1)) || stat.last;
        stat.div_done  = (k_reg == 3'd0);
    end

    always_comb begin
        used_we = (cmd.op == OP_CLEAR) || (cmd.op == OP_A_MARK) || (cmd.op == OP_F_CLR);
        used_wd = (cmd.op == OP_A_MARK);
        run_we  = (cmd.op == OP_CLEAR) || ((cmd.op == OP_A_MARK) && (idx_reg == start_reg))
                  || ((cmd.op == OP_F_LEN) && !stat.len_zero);
        run_wd  = (cmd.op == OP_A_MARK) ? cnt_reg : '0;
        div_term = NW'(free_reg) << k_reg;
    end

    always_comb begin
        base_next     = cfg_we ? cfg_wdata : base_reg;
        idx_next      = idx_reg;
        mode_next     = mode_reg;
        size_next     = size_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        rb_next       = rb_reg;
        acur_next     = acur_reg;
        run_addr_next = run_addr_reg;
        start_next    = start_reg;
        used_next     = used_reg;
        cur_next      = cur_reg;
        longest_next  = longest_reg;
        free_next     = free_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        k_next        = k_reg;
        o_status_next = o_status_reg;
        o_addr_next   = o_addr_reg;
        o_alloc_next  = o_alloc_reg;
        o_free_next   = o_free_reg;
        o_long_next   = o_long_reg;
        o_frag_next   = o_frag_reg;
        case (cmd.op)
            OP_CLEAR: begin
                idx_next = idx_reg + IW'(1);
            end
            OP_START: begin
                mode_next     = in_mode;
                size_next     = in_size;
                addr_next     = in_address;
                idx_next      = '0;
                cnt_next      = '0;
                rb_next       = '0;
                acur_next     = {1'b0, base_reg};
                run_addr_next = {1'b0, base_reg};
                used_next     = '0;
                cur_next      = '0;
                longest_next  = '0;
            end
            OP_A_EVAL: begin
                if (used_q) begin
                    cnt_next      = '0;
                    rb_next       = '0;
                    run_addr_next = acur_reg + XW'(BLOCK_BYTES);
                    idx_next      = idx_reg + IW'(1);
                    acur_next     = acur_reg + XW'(BLOCK_BYTES);
                end else if (stat.a_hit) begin
                    // The run is complete; rewind to its first block for marking.
                    start_next = idx_reg - cnt_reg;
                    idx_next   = idx_reg - cnt_reg;
                    cnt_next   = cnt_reg + IW'(1);
                end else begin
                    cnt_next  = cnt_reg + IW'(1);
                    rb_next   = rb_reg + RBW'(BLOCK_BYTES);
                    idx_next  = idx_reg + IW'(1);
                    acur_next = acur_reg + XW'(BLOCK_BYTES);
                end
            end
            OP_A_MARK: begin
                idx_next = idx_reg + IW'(1);
            end
            OP_F_EVAL: begin
                if (!stat.f_match) begin
                    idx_next  = idx_reg + IW'(1);
                    acur_next = acur_reg + XW'(BLOCK_BYTES);
                end
            end
            OP_F_LEN: begin
                cnt_next = run_q;
            end
            OP_F_CLR: begin
                idx_next = idx_reg + IW'(1);
                cnt_next = cnt_reg - IW'(1);
            end
            OP_S_EVAL: begin
                idx_next = idx_reg + IW'(1);
                if (used_q) begin
                    used_next = used_reg + IW'(1);
                    cur_next  = '0;
                end else begin
                    cur_next = cur_reg + IW'(1);
                    if (cur_reg + IW'(1) > longest_reg) begin
                        longest_next = cur_reg + IW'(1);
                    end
                end
            end
            OP_DIV_INIT: begin
                free_next = IW'(NUM_BLOCKS) - used_reg;
                rem_next  = NW'(IW'(NUM_BLOCKS) - used_reg - longest_reg) * NW'(100);
                quo_next  = '0;
                k_next    = 3'd6;
            end
            OP_DIV_STEP: begin
                if (rem_reg >= div_term) begin
                    rem_next          = rem_reg - div_term;
                    quo_next[k_reg]   = 1'b1;
                end
                k_next = k_reg - 3'd1;
            end
            OP_FIN: begin
                o_status_next = cmd.status;
                o_addr_next   = ((cmd.status == ST_OK) && (mode_reg == MODE_ALLOC)) ?
                                run_addr_reg[ADDR_W-1:0] : '0;
                if (mode_reg[1]) begin
                    o_alloc_next = used_reg[CNT_W-1:0];
                    o_free_next  = free_reg[CNT_W-1:0];
                    o_long_next  = longest_reg[CNT_W-1:0];
                    o_frag_next  = (free_reg == '0) ? '0 : quo_reg;
                end else begin
                    o_alloc_next = '0;
                    o_free_next  = '0;
                    o_long_next  = '0;
                    o_frag_next  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            idx_reg  <= '0;
        end else begin
            base_reg <= base_next;
            idx_reg  <= idx_next;
        end
        mode_reg     <= mode_next;
        size_reg     <= size_next;
        addr_reg     <= addr_next;
        cnt_reg      <= cnt_next;
        rb_reg       <= rb_next;
        acur_reg     <= acur_next;
        run_addr_reg <= run_addr_next;
        start_reg    <= start_next;
        used_reg     <= used_next;
        cur_reg      <= cur_next;
        longest_reg  <= longest_next;
        free_reg     <= free_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        k_reg        <= k_next;
        o_status_reg <= o_status_next;
        o_addr_reg   <= o_addr_next;
        o_alloc_reg  <= o_alloc_next;
        o_free_reg   <= o_free_next;
        o_long_reg   <= o_long_next;
        o_frag_reg   <= o_frag_next;
    end

    assign out_status           = o_status_reg;
    assign out_block_address    = o_addr_reg;
    assign out_used_count       = o_alloc_reg;
    assign out_avail_count      = o_free_reg;
    assign out_longest_free_run = o_long_reg;
    assign out_frag_pct         = o_frag_reg;

    a_stats_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_FIN && mode_reg[1]) |=>
        (CNT_W'(o_alloc_reg + o_free_reg) == CNT_W'(NUM_BLOCKS)))
        else $error("used plus free blocks do not cover the pool");

    a_longest_le_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_DIV_INIT) |-> (longest_reg + used_reg <= IW'(NUM_BLOCKS)))
        else $error("longest free run exceeds free blocks");

    a_mark_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_A_MARK || cmd.op == OP_F_CLR) |-> (idx_reg < IW'(NUM_BLOCKS)))
        else $error("block update outside the pool");

endmodule

/* rtl/bba_ctrl.sv */
`timescale 1ns / 1ps

module bba_ctrl import bba_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  stat_t stat,
    output cmd_t  cmd,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISP, S_A_RD, S_A_EV, S_A_MARK, S_F_SRCH, S_F_LEN,
        S_F_CLR, S_S_RD, S_S_EV, S_DIV_INIT, S_DIV, S_FIN, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] fin_reg, fin_next;
    logic       s_ready_reg, s_ready_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        fin_next     = fin_reg;
        cmd.op       = OP_IDLE;
        cmd.status   = fin_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (stat.last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_START;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (stat.mode == MODE_ALLOC) begin
                    if (stat.size_zero) begin
                        fin_next   = ST_ZERO_SIZE;
                        state_next = S_FIN;
                    end else begin
                        state_next = S_A_RD;
                    end
                end else if (stat.mode == MODE_FREE) begin
                    if (stat.addr_zero) begin
                        fin_next   = ST_INVALID;
                        state_next = S_FIN;
                    end else begin
                        state_next = S_F_SRCH;
                    end
                end else begin
                    state_next = S_S_RD;
                end
            end
            S_A_RD: state_next = S_A_EV;
            S_A_EV: begin
                cmd.op = OP_A_EVAL;
                if (stat.a_hit) begin
                    state_next = S_A_MARK;
                end else if (stat.last) begin
                    fin_next   = ST_NO_SPACE;
                    state_next = S_FIN;
                end else begin
                    state_next = S_A_RD;
                end
            end
            S_A_MARK: begin
                cmd.op = OP_A_MARK;
                if (stat.mark_done) begin
                    fin_next   = ST_OK;
                    state_next = S_FIN;
                end
            end
            S_F_SRCH: begin
                cmd.op = OP_F_EVAL;
                if (stat.f_match) begin
                    state_next = S_F_LEN;
                end else if (stat.last) begin
                    fin_next   = ST_INVALID;
                    state_next = S_FIN;
                end
            end
            S_F_LEN: begin
                cmd.op = OP_F_LEN;
                if (stat.len_zero) begin
                    fin_next   = ST_NOT_FOUND;
                    state_next = S_FIN;
                end else begin
                    state_next = S_F_CLR;
                end
            end
            S_F_CLR: begin
                cmd.op = OP_F_CLR;
                if (stat.clr_done) begin
                    fin_next   = ST_OK;
                    state_next = S_FIN;
                end
            end
            S_S_RD: state_next = S_S_EV;
            S_S_EV: begin
                cmd.op     = OP_S_EVAL;
                state_next = stat.last ? S_DIV_INIT : S_S_RD;
            end
            S_DIV_INIT: begin
                cmd.op     = OP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_done) begin
                    fin_next   = ST_OK;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                cmd.op     = OP_FIN;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        s_ready_next = (state_next == S_IDLE);
        m_valid_next = (state_next == S_OUT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            fin_reg     <= ST_OK;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fin_reg     <= fin_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = s_ready_reg;
    assign m_tvalid = m_valid_reg;

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready_reg && m_valid_reg))
        else $error("input taken while a result is pending");

    a_fin_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN) |=> m_valid_reg)
        else $error("finished request not presented");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready_reg |-> (state_reg == S_IDLE))
        else $error("ready outside idle");

endmodule

/* rtl/bitmap_block_allocator_top.sv */
`timescale 1ns / 1ps
// Channel   Direction  Beat contents
// s_axis    in         mode, size_bytes, address
// m_axis    out        status, block_address, used_count, avail_count,
//                      longest_free_run, frag_pct
// cfg       in         pool_base
// One request at a time; a dispatch state follows the accepting beat and a finish state
// loads the result. Allocate scans the blocks until a run fits or the pool ends, then
// marks the run. Free searches up to NUM_BLOCKS addresses, one a cycle, then reads the
// run length and releases one block a cycle. Statistics read and evaluate every block,
// then run a bit-serial percentage divide. After reset a clearing pass over all blocks
// runs before s_tready rises; a result holds on m_tdata until taken, blocking input.

module bitmap_block_allocator_top import bba_pkg::*; #(
    parameter int NUM_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [79:0]       s_tdata,   // mode[1:0], size_bytes[25:2], address[73:26]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [95:0]       m_tdata    // status[2:0], block_address[50:3],
                                         // used_count[61:51], avail_count[72:62],
                                         // longest_free_run[83:73],
                                         // frag_pct[90:84]
);

    cmd_t              cmd;
    stat_t             stat;
    logic [2:0]        o_status;
    logic [ADDR_W-1:0] o_addr;
    logic [CNT_W-1:0]  o_alloc, o_free, o_long;
    logic [FRAG_W-1:0] o_frag;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (stat),
        .cmd      (cmd),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    bba_dpath #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dpath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .stat                 (stat),
        .cfg_we               (cfg_we),
        .cfg_wdata            (cfg_wdata),
        .in_mode              (s_tdata[1:0]),
        .in_size              (s_tdata[25:2]),
        .in_address           (s_tdata[73:26]),
        .out_status           (o_status),
        .out_block_address    (o_addr),
        .out_used_count       (o_alloc),
        .out_avail_count      (o_free),
        .out_longest_free_run (o_long),
        .out_frag_pct         (o_frag)
    );

    assign m_tdata = {5'd0, o_frag, o_long, o_free, o_alloc, o_addr, o_status};

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import bba_pkg::*;

    localparam int NBLK = 1024;
    localparam int BBYTES = 4096;
    localparam int WDOG_LIMIT = 60000;
    localparam logic [1:0] MODE_STATS = 2'd2;
    localparam logic [1:0] MODE_STATS_ALT = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [MODE_W-1:0] mode;
    } req_t;

    typedef struct {
        logic [2:0]        status;
        logic [ADDR_W-1:0] baddr;
        logic [CNT_W-1:0]  used_cnt;
        logic [CNT_W-1:0]  free_cnt;
        logic [CNT_W-1:0]  longest;
        logic [FRAG_W-1:0] frag;
    } resp_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [ADDR_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [79:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [95:0] m_tdata;

    bitmap_block_allocator_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Shadow allocator state.
    logic [ADDR_W-1:0] shadow_base;
    bit               shadow_used [NBLK];
    int unsigned      shadow_len [NBLK];
    logic [ADDR_W-1:0] live_addrs [$];

    req_t  pending_reqs [$];
    resp_t expected_resps [$];
    int    errors = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    quiet_cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic resp_t predict_request(req_t r);
        resp_t o;
        longint unsigned need, cnt, off, idx, used, fr, lg, cur;
        int start;
        o = '{default: '0};
        start = -1;
        if (r.mode == MODE_ALLOC) begin
            if (r.size == 0) begin
                o.status = ST_ZERO_SIZE;
            end else begin
                need = (longint'(r.size) + BBYTES - 1) / BBYTES;
                cnt = 0;
                if (need <= NBLK) begin
                    for (int i = 0; i < NBLK; i++) begin
                        if (shadow_used[i]) begin
                            cnt = 0;
                        end else begin
                            cnt++;
                            if (cnt == need) begin
                                start = i + 1 - int'(need);
                                break;
                            end
                        end
                    end
                end
                if (start < 0) begin
                    o.status = ST_NO_SPACE;
                end else begin
                    for (int i = 0; i < need; i++) shadow_used[start + i] = 1;
                    shadow_len[start] = 32'(need);
                    o.status = ST_OK;
                    o.baddr = shadow_base + ADDR_W'(start) * ADDR_W'(BBYTES);
                    live_addrs.push_back(o.baddr);
                end
            end
        end else if (r.mode == MODE_FREE) begin
            off = longint'(r.addr) - longint'(shadow_base);
            if (r.addr == 0 || r.addr < shadow_base) begin
                o.status = ST_INVALID;
            end else if (off >= longint'(NBLK) * BBYTES || off % BBYTES != 0) begin
                o.status = ST_INVALID;
            end else begin
                idx = off / BBYTES;
                if (shadow_len[idx] == 0) begin
                    o.status = ST_NOT_FOUND;
                end else begin
                    for (longint unsigned i = 0; i < shadow_len[idx] && idx + i < NBLK; i++)
                        shadow_used[idx + i] = 0;
                    shadow_len[idx] = 0;
                    o.status = ST_OK;
                end
            end
        end else begin
            used = 0; lg = 0; cur = 0;
            for (int i = 0; i < NBLK; i++) begin
                if (shadow_used[i]) begin
                    used++;
                    cur = 0;
                end else begin
                    cur++;
                    if (cur > lg) lg = cur;
                end
            end
            fr = NBLK - used;
            o.status = ST_OK;
            o.used_cnt = CNT_W'(used);
            o.free_cnt = CNT_W'(fr);
            o.longest = CNT_W'(lg);
            o.frag = (fr > 0) ? FRAG_W'((fr - lg) * 100 / fr) : '0;
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Driver: presents the head of the pending queue.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_resps.push_back(predict_request(pending_reqs.pop_front()));
            end
            if ((!s_tvalid || s_tready) ) begin
                if (pending_reqs.size() > 0 && (s_tvalid && s_tready ? pending_reqs.size() > 0 : 1)
                    && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1;
                    s_tdata <= {6'd0, pending_reqs[0]};
                end else begin
                    s_tvalid <= 0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compares each result beat with the oldest expectation.
    always @(posedge aclk) begin
        resp_t w;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (expected_resps.size() == 0) begin
                    report_mismatch("unexpected beat", 64'(m_tdata), 0);
                end else begin
                    w = expected_resps.pop_front();
                    if (m_tdata[2:0] != w.status) report_mismatch("status", m_tdata[2:0], w.status);
                    if (m_tdata[50:3] != w.baddr)
                        report_mismatch("block_address", m_tdata[50:3], w.baddr);
                    if (m_tdata[61:51] != w.used_cnt)
                        report_mismatch("used_count", m_tdata[61:51], w.used_cnt);
                    if (m_tdata[72:62] != w.free_cnt)
                        report_mismatch("avail_count", m_tdata[72:62], w.free_cnt);
                    if (m_tdata[83:73] != w.longest)
                        report_mismatch("longest_free_run", m_tdata[83:73], w.longest);
                    if (m_tdata[90:84] != w.frag)
                        report_mismatch("frag_pct", m_tdata[90:84], w.frag);
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic req_t make_req(logic [1:0] m, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] a);
        req_t r;
        r.mode = m; r.size = sz; r.addr = a;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    // Mostly well-formed traffic: frees of live runs, modest allocations, statistics, a few wild beats.
    function automatic req_t random_req();
        int pick;
        logic [ADDR_W-1:0] a;
        pick = $urandom_range(99);
        if (pick < 40) begin
            return make_req(MODE_ALLOC, ($urandom_range(9) == 0) ? SIZE_W'($urandom)
                            : SIZE_W'($urandom_range(1, 16 * BBYTES)), rand48());
        end else if (pick < 75 && live_addrs.size() > 0) begin
            a = live_addrs[$urandom_range(live_addrs.size() - 1)];
            return make_req(MODE_FREE, SIZE_W'($urandom), a);
        end else if (pick < 85) begin
            a = shadow_base + ADDR_W'($urandom_range(NBLK)) * BBYTES
                + (($urandom_range(3) == 0) ? ADDR_W'($urandom_range(BBYTES - 1)) : 0);
            return make_req(MODE_FREE, SIZE_W'($urandom), a);
        end else if (pick < 90) begin
            return make_req(MODE_FREE, SIZE_W'($urandom), rand48());
        end
        return make_req($urandom_range(1) ? MODE_STATS : MODE_STATS_ALT, SIZE_W'($urandom),
                        rand48());
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_resps.size() > 0) @(posedge aclk);
        repeat (2 * NBLK + 3 * NBLK + 50) @(posedge aclk);
    endtask

    task automatic write_base(logic [ADDR_W-1:0] b);
        cfg_we <= 1;
        cfg_wdata <= b;
        @(posedge aclk);
        cfg_we <= 0;
        shadow_base = b;
        live_addrs.delete();
    endtask

    logic [ADDR_W-1:0] bases [5];

    initial begin
        shadow_base = 0;
        foreach (shadow_used[i]) begin
            shadow_used[i] = 0;
            shadow_len[i] = 0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        write_base(48'h0000_0010_0000);

        // Directed: field extremes and every special case.
        pending_reqs.push_back(make_req(MODE_STATS, 0, 0));
        pending_reqs.push_back(make_req(MODE_ALLOC, 0, 0));
        pending_reqs.push_back(make_req(MODE_ALLOC, 24'hFF_FFFF, '1));
        pending_reqs.push_back(make_req(MODE_ALLOC, 1, 0));
        pending_reqs.push_back(make_req(MODE_ALLOC, BBYTES + 1, 0));
        pending_reqs.push_back(make_req(MODE_ALLOC, NBLK * BBYTES, 0));
        pending_reqs.push_back(make_req(MODE_FREE, 0, 0));
        pending_reqs.push_back(make_req(MODE_FREE, 0, 48'h0000_000F_F000));
        pending_reqs.push_back(make_req(MODE_FREE, 0, 48'h0000_0050_0000));
        pending_reqs.push_back(make_req(MODE_FREE, 0, 48'h0000_0010_0001));
        pending_reqs.push_back(make_req(MODE_FREE, 0, '1));
        pending_reqs.push_back(make_req(MODE_FREE, 0, 48'h0000_0010_0000));
        pending_reqs.push_back(make_req(MODE_FREE, 0, 48'h0000_0010_0000));
        pending_reqs.push_back(make_req(MODE_FREE, 0, 48'h0000_0010_2000));
        pending_reqs.push_back(make_req(MODE_STATS_ALT, 24'hFF_FFFF, '1));
        pending_reqs.push_back(make_req(MODE_ALLOC, NBLK * BBYTES, 0));
        pending_reqs.push_back(make_req(MODE_ALLOC, 1, 0));
        pending_reqs.push_back(make_req(MODE_STATS, 0, 0));
        pending_reqs.push_back(make_req(MODE_FREE, 0, 48'h0000_0010_0000));
        pending_reqs.push_back(make_req(MODE_STATS, 0, 0));
        drain();

        // The pool base wraps the returned address at the top of the range.
        bases = '{48'h0, 48'hFFFF_FFFF_F000, 48'h1234_5678_9000, 48'h8000_0000_0001,
                  48'h0000_0000_0000};
        for (int ph = 0; ph < 4; ph++) begin
            write_base(bases[ph]);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            // Keep only a short backlog so each request sees the shadow state it frees from.
            for (int n = 0; n < 350; n++) begin
                while (pending_reqs.size() > 2) @(posedge aclk);
                pending_reqs.push_back(random_req());
            end
            drain();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/bba_pkg.sv
rtl/bba_dpath.sv
rtl/bba_ctrl.sv
rtl/bitmap_block_allocator_top.sv
dv/tb_top.sv
